>>> hdl/lssr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the LIFO key store with search and remove.
// No dependencies; used by the top level and the checker.
package lssr_pkg;

  localparam int DEPTH_DEF     = 8;
  localparam int KEY_BYTES_DEF = 7;
  localparam int KEY_FIELD_W   = 56;
  localparam int MOVES_W       = 3;
  localparam int OCC_W         = 4;

  // request kinds
  localparam logic REQ_ARRIVAL   = 1'b0;
  localparam logic REQ_DEPARTURE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_STORED    = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_REMOVED   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                   req_type;
    logic [KEY_FIELD_W-1:0] plate_key;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [MOVES_W-1:0] moves;
    logic [OCC_W-1:0]   occupancy;
  } result_t;

endpackage

>>> hdl/lssr_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/lifo_store_search_remove.sv
`timescale 1ns / 1ps
// Top level of the LIFO key store with search and remove.
// Depends on lssr_pkg (types, codes) and lssr_ram (key storage).
//
// Usage:
//   A request (arrival or departure plus a key) is taken at a rising edge
//   where start is high and busy is low. Each request yields exactly one
//   result on result, marked by done for one cycle; the receiver cannot
//   stall, so it must take the result in that cycle.
//   An arrival, and a departure on an empty store, finish in the accept
//   cycle: done rises in the cycle after the accept and busy stays low, so a
//   new request may follow at once.
//   A departure searches the store from the top, one entry per cycle out of the
//   RAM read port (registered read), then moves each entry above the
//   match down one slot, one RAM read and write per cycle; busy is high
//   while the search and shift run.
//   Reset (rst, synchronous) empties the store and clears busy and done;
//   RAM contents are left as they are, since only slots below the fill
//   count are ever read.
//   Read and write never target the same slot in one cycle: the shift
//   writes slot j while it reads slot j+2, and a departure reads only in
//   the cycles after any arrival write has landed.
module lifo_store_search_remove #(
  parameter int DEPTH     = lssr_pkg::DEPTH_DEF,
  parameter int KEY_BYTES = lssr_pkg::KEY_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lssr_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output lssr_pkg::result_t  result
);

  localparam int KEY_W  = (8 * KEY_BYTES > lssr_pkg::KEY_FIELD_W) ?
                          lssr_pkg::KEY_FIELD_W : 8 * KEY_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_SHIFT  = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    fill, fill_next;
  logic [ADDR_W-1:0]   ptr, ptr_next;
  logic [KEY_W-1:0]    key, key_next;
  logic [lssr_pkg::MOVES_W-1:0] moves, moves_next;
  logic                done_next;
  lssr_pkg::result_t   result_next;

  // RAM port signals
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [KEY_W-1:0]    wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [KEY_W-1:0]    rd_data;

  // helper arithmetic on the pointer and fill count
  logic [CNT_W-1:0]    ptr_ext;
  logic [CNT_W-1:0]    fill_m1;
  logic [CNT_W:0]      ptr_p2;
  logic [KEY_W-1:0]    in_key;
  logic                match;

  assign ptr_ext = CNT_W'(ptr);
  assign fill_m1 = fill - CNT_W'(1);
  assign ptr_p2  = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(2);
  assign in_key  = request.plate_key[KEY_W-1:0];
  assign match   = (rd_data == key);

  lssr_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    ptr_next    = ptr;
    key_next    = key;
    moves_next  = moves;
    done_next   = 1'b0;
    result_next = result;
    wr_en       = 1'b0;
    wr_addr     = ptr;
    wr_data     = rd_data;
    rd_en       = 1'b0;
    rd_addr     = ptr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          key_next = in_key;
          if (request.req_type == lssr_pkg::REQ_ARRIVAL) begin
            done_next = 1'b1;
            if (fill == CNT_W'(DEPTH)) begin
              // store full: reject, leave contents
              result_next.status    = lssr_pkg::ST_FULL;
              result_next.moves     = '0;
              result_next.occupancy = lssr_pkg::OCC_W'(fill);
            end else begin
              // push on top
              wr_en                 = 1'b1;
              wr_addr               = ADDR_W'(fill);
              wr_data               = in_key;
              fill_next             = fill + CNT_W'(1);
              result_next.status    = lssr_pkg::ST_STORED;
              result_next.moves     = '0;
              result_next.occupancy = lssr_pkg::OCC_W'(fill + CNT_W'(1));
            end
          end else if (fill == '0) begin
            // departure on an empty store
            done_next             = 1'b1;
            result_next.status    = lssr_pkg::ST_NOT_FOUND;
            result_next.moves     = '0;
            result_next.occupancy = lssr_pkg::OCC_W'(fill);
          end else begin
            // start the search at the top entry
            rd_en      = 1'b1;
            rd_addr    = ADDR_W'(fill_m1);
            ptr_next   = ADDR_W'(fill_m1);
            state_next = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        // rd_data holds the slot at ptr
        if (match) begin
          if (ptr_ext == fill_m1) begin
            // top entry matched: drop it, nothing to move
            fill_next             = fill_m1;
            done_next             = 1'b1;
            result_next.status    = lssr_pkg::ST_REMOVED;
            result_next.moves     = '0;
            result_next.occupancy = lssr_pkg::OCC_W'(fill_m1);
            state_next            = S_IDLE;
          end else begin
            // fetch the entry just above the match, then shift down
            rd_en      = 1'b1;
            rd_addr    = ADDR_W'(ptr_ext + CNT_W'(1));
            moves_next = lssr_pkg::MOVES_W'(fill_m1 - ptr_ext);
            state_next = S_SHIFT;
          end
        end else if (ptr == '0) begin
          done_next             = 1'b1;
          result_next.status    = lssr_pkg::ST_NOT_FOUND;
          result_next.moves     = '0;
          result_next.occupancy = lssr_pkg::OCC_W'(fill);
          state_next            = S_IDLE;
        end else begin
          // advance one entry down
          rd_en    = 1'b1;
          rd_addr  = ptr - ADDR_W'(1);
          ptr_next = ptr - ADDR_W'(1);
        end
      end

      S_SHIFT: begin
        // rd_data holds slot ptr+1; write it into slot ptr
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_data = rd_data;
        if (ptr_p2 == (CNT_W + 1)'(fill)) begin
          fill_next             = fill_m1;
          done_next             = 1'b1;
          result_next.status    = lssr_pkg::ST_REMOVED;
          result_next.moves     = moves;
          result_next.occupancy = lssr_pkg::OCC_W'(fill_m1);
          state_next            = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = ADDR_W'(ptr_p2);
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    key    <= key_next;
    moves  <= moves_next;
    result <= result_next;
  end

  assign busy = (state != S_IDLE);

endmodule

>>> hdl/lssr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for lifo_store_search_remove, bound to the top level.
// Depends on lssr_pkg and the top level's port names.
module lssr_checker #(
  parameter int DEPTH = lssr_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input lssr_pkg::result_t  result
);

  // a result never shows while a departure is still in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // each accepted request either reports next cycle or holds busy
  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted request neither reported nor in progress");

  // a departure ends with a result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // moves reported only for a removal
  a_moves_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != lssr_pkg::ST_REMOVED) |-> (result.moves == '0))
    else $error("nonzero moves on a non-removal result");

  // occupancy stays within the store depth (checked only for DEPTH up to 15)
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (DEPTH > 15 || 32'(result.occupancy) <= DEPTH))
    else $error("occupancy above store depth");

endmodule

bind lifo_store_search_remove lssr_checker #(.DEPTH(DEPTH)) u_lssr_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
